// File: hw/rtl/lphs_pkg.sv
// lphs_pkg: shared constants, status codes and control/status structs
// for the linear probing hash set. no dependencies.

package lphs_pkg;

    // table geometry
    localparam int SLOTS      = 4096;
    localparam int CATEGORIES = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CAT_W      = $clog2(CATEGORIES);
    localparam int ADDR_W     = CAT_W + SLOT_W;
    localparam int TOTAL      = CATEGORIES * SLOTS;

    // field widths
    localparam int CMD_W      = 1;
    localparam int CAT_FIELD_W = 5;
    localparam int KEY_W      = 63;
    localparam int STATUS_W   = 3;
    localparam int SLOT_FIELD_W = 12;
    localparam int COUNT_W    = 13;

    // murmur3 finaliser constants
    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SHIFT = 33;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

    // result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_PRESENT  = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_FOUND    = 3'd3;
    localparam status_t ST_MISSING  = 3'd4;
    localparam status_t ST_INVALID  = 3'd5;

    // hash sequencer phases
    localparam logic [2:0] PH_MIX_MID = 3'd3;
    localparam logic [2:0] PH_LAST    = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // take the request payload
        logic clr_write;   // write zero at the clearing address
        logic hash_step;   // advance the hash sequencer
        logic probe_step;  // check one slot
        logic post;        // move the result into the output register
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;    // clearing pass at its last entry
        logic key_zero;    // requested identifier is zero
        logic hash_last;   // hash sequencer in its final phase
        logic resolved;    // probe finished this cycle
        logic rsp_free;    // output register can take a result
    } dp_stat_t;

endpackage

// File: hw/rtl/lphs_ram.sv
// lphs_ram: generic single write, single read RAM with registered read.
// no dependencies.

module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lphs_dp.sv
// lphs_dp: datapath of the hash set: request registers, finaliser with one
// shared 32x32 multiplier, probe pointer, key memory, counts, result register.
// depends on lphs_pkg and lphs_ram.

module lphs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lphs_pkg::ctrl_cmd_t                 cmd,
    output lphs_pkg::dp_stat_t                  stat,
    input  logic [lphs_pkg::CMD_W-1:0]          command,
    input  logic [lphs_pkg::CAT_FIELD_W-1:0]    category,
    input  logic [lphs_pkg::KEY_W-1:0]          title_id,
    input  logic                                rsp_stall,
    output logic                                rsp_valid,
    output logic [lphs_pkg::STATUS_W-1:0]       status,
    output logic [lphs_pkg::SLOT_FIELD_W-1:0]   slot_index,
    output logic [lphs_pkg::COUNT_W-1:0]        record_count
);
    import lphs_pkg::*;

    // request registers
    logic [CMD_W-1:0]   op_reg;
    logic [CAT_W-1:0]   cat_reg;
    logic [KEY_W-1:0]   key_reg;

    // hash sequencer
    logic [2:0]         phase_reg;
    logic [63:0]        v_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        key_ext;
    logic [63:0]        mix_const;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_prod;
    logic [63:0]        fin_mix;
    logic [SLOT_W-1:0]  home;

    // probe
    logic [SLOT_W-1:0]  pos_reg;
    logic [SLOT_W-1:0]  probes_reg;
    logic [SLOT_W-1:0]  pos_inc;
    logic               probe_last;
    logic               hit;
    logic               empty;
    logic               do_insert;

    // clearing pass
    logic [ADDR_W-1:0]  clr_addr_reg;

    // key memory ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    // per category counts
    logic [COUNT_W-1:0] count_reg [CATEGORIES];
    logic [COUNT_W-1:0] count_cur;

    // pending result
    status_t            res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;

    // output register
    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic [SLOT_FIELD_W-1:0] rsp_slot_reg;
    logic [COUNT_W-1:0] rsp_count_reg;

    // identifier zero-extended to 64 bits for the first xor-shift
    assign key_ext = {1'b0, title_id};

    // one partial product per phase, low 64 bits of v * c over three phases
    always_comb
    begin
        mix_const = phase_reg[2] ? MIX_C2 : MIX_C1;
        case (phase_reg[1:0])
            2'd0:
            begin
                mul_a = v_reg[31:0];
                mul_b = mix_const[31:0];
            end
            2'd1:
            begin
                mul_a = v_reg[31:0];
                mul_b = mix_const[63:32];
            end
            default:
            begin
                mul_a = v_reg[63:32];
                mul_b = mix_const[31:0];
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign fin_mix  = acc_reg ^ (acc_reg >> MIX_SHIFT);
    assign home     = fin_mix[SLOT_W-1:0];

    // probe compare and next slot with wrap
    assign hit        = (ram_rdata == key_reg);
    assign empty      = (ram_rdata == '0);
    assign probe_last = (probes_reg == SLOT_W'(SLOTS - 1));
    assign pos_inc    = (pos_reg == SLOT_W'(SLOTS - 1)) ? '0 : pos_reg + 1'b1;
    assign do_insert  = cmd.probe_step && !hit && empty && (op_reg == CMD_INSERT);

    assign count_cur  = count_reg[cat_reg];

    // key memory port selection
    always_comb
    begin
        ram_we    = cmd.clr_write || do_insert;
        ram_waddr = cmd.clr_write ? clr_addr_reg : {cat_reg, pos_reg};
        ram_wdata = cmd.clr_write ? '0 : key_reg;
        ram_raddr = cmd.hash_step ? {cat_reg, home} : {cat_reg, pos_inc};
    end

    lphs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOTAL)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request capture, hash sequencer, probe pointer and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= command;
            cat_reg   <= category[CAT_W-1:0];
            key_reg   <= title_id;
            v_reg     <= key_ext ^ (key_ext >> MIX_SHIFT);
            phase_reg <= '0;
            res_status_reg <= ST_INVALID;
            res_slot_reg   <= '0;
        end
        else if (cmd.hash_step)
        begin
            phase_reg <= phase_reg + 1'b1;
            if (phase_reg == PH_MIX_MID)
            begin
                v_reg <= fin_mix;
            end
            else if (phase_reg == PH_LAST)
            begin
                pos_reg    <= home;
                probes_reg <= '0;
            end
            else if (phase_reg[1:0] == 2'd0)
            begin
                acc_reg <= mul_prod;
            end
            else
            begin
                acc_reg[63:32] <= acc_reg[63:32] + mul_prod[31:0];
            end
        end
        else if (cmd.probe_step)
        begin
            pos_reg    <= pos_inc;
            probes_reg <= probes_reg + 1'b1;
            if (hit)
            begin
                res_status_reg <= (op_reg == CMD_LOOKUP) ? ST_FOUND : ST_PRESENT;
                res_slot_reg   <= pos_reg;
            end
            else if (empty)
            begin
                res_status_reg <= (op_reg == CMD_LOOKUP) ? ST_MISSING : ST_INSERTED;
                res_slot_reg   <= (op_reg == CMD_INSERT) ? pos_reg : '0;
            end
            else
            begin
                res_status_reg <= (op_reg == CMD_LOOKUP) ? ST_MISSING : ST_FULL;
                res_slot_reg   <= '0;
            end
        end
    end

    // clearing address and per category counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            for (int i = 0; i < CATEGORIES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (do_insert)
            begin
                count_reg[cat_reg] <= count_cur + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_slot_reg   <= SLOT_FIELD_W'(res_slot_reg);
            rsp_count_reg  <= count_cur;
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.clr_last  = (clr_addr_reg == ADDR_W'(TOTAL - 1));
        stat.key_zero  = (title_id == '0);
        stat.hash_last = (phase_reg == PH_LAST);
        stat.resolved  = hit || empty || probe_last;
        stat.rsp_free  = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign slot_index   = rsp_slot_reg;
    assign record_count = rsp_count_reg;

endmodule

// File: hw/rtl/lphs_ctrl.sv
// lphs_ctrl: controller state machine of the hash set: clearing pass,
// request intake, hash sequencing, probing and result hand-off.
// depends on lphs_pkg.

module lphs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  lphs_pkg::dp_stat_t   stat,
    output lphs_pkg::ctrl_cmd_t  cmd
);
    import lphs_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.key_zero ? S_DONE : S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe_step = 1'b1;
                if (stat.resolved)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/linear_probe_hash_set.sv
// linear_probe_hash_set: top level of the per-category linear probing hash
// set. depends on lphs_pkg, lphs_ctrl, lphs_dp (and lphs_ram through it).
//
//  channel   handshake            payload
//  request   req_valid/req_stall  command, category, title_id
//  result    rsp_valid/rsp_stall  status, slot_index, record_count
//
// one request at a time: each request is loaded, hashed by the finaliser on
// one shared 32x32 multiplier, then p (1..4096) slots are probed, one per
// cycle on the key memory read port. a zero identifier skips hashing and
// probing. after reset a clearing pass writes the 131072-entry key memory,
// one entry a cycle; requests stall until it ends. a result waiting under
// rsp_stall does not block intake of the next request.

module linear_probe_hash_set (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [lphs_pkg::CMD_W-1:0]          command,
    input  logic [lphs_pkg::CAT_FIELD_W-1:0]    category,
    input  logic [lphs_pkg::KEY_W-1:0]          title_id,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [lphs_pkg::STATUS_W-1:0]       status,
    output logic [lphs_pkg::SLOT_FIELD_W-1:0]   slot_index,
    output logic [lphs_pkg::COUNT_W-1:0]        record_count
);
    import lphs_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // controller
    lphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    lphs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .category     (category),
        .title_id     (title_id),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .status       (status),
        .slot_index   (slot_index),
        .record_count (record_count)
    );

endmodule

// File: hw/rtl/lphs_checker.sv
// lphs_checker: port-level checks on the hash set, bound to the top level.
// depends on lphs_pkg and linear_probe_hash_set.

module lphs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [lphs_pkg::CMD_W-1:0]          command,
    input  logic [lphs_pkg::CAT_FIELD_W-1:0]    category,
    input  logic [lphs_pkg::KEY_W-1:0]          title_id,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [lphs_pkg::STATUS_W-1:0]       status,
    input  logic [lphs_pkg::SLOT_FIELD_W-1:0]   slot_index,
    input  logic [lphs_pkg::COUNT_W-1:0]        record_count
);
    import lphs_pkg::*;

    // one request in flight: intake closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another was in flight");

    // misses, full tables and bad identifiers report slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_FULL || status == ST_MISSING ||
                       status == ST_INVALID)) |-> (slot_index == '0))
        else $error("slot index not zero on a miss");

    // a fresh insert leaves at least one key in the category
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_INSERTED) |-> (record_count != '0))
        else $error("insert reported with empty category");

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (record_count <= COUNT_W'(SLOTS)))
        else $error("record count above slot count");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) &&
            $stable(slot_index) && $stable(record_count)))
        else $error("stalled result changed");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

// File: tb/lphs_monitor.sv
// lphs_monitor: watches both channels of linear_probe_hash_set, keeps its own
// copy of the category tables and checks every result against it.
// depends on lphs_pkg.

module lphs_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [lphs_pkg::CMD_W-1:0]          command,
    input  logic [lphs_pkg::CAT_FIELD_W-1:0]    category,
    input  logic [lphs_pkg::KEY_W-1:0]          title_id,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [lphs_pkg::STATUS_W-1:0]       status,
    input  logic [lphs_pkg::SLOT_FIELD_W-1:0]   slot_index,
    input  logic [lphs_pkg::COUNT_W-1:0]        record_count,
    output int                                  outstanding,
    output int                                  failures
);

    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    typedef struct packed {
        status_t                  st;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_W-1:0]       count;
    } set_answer_t;

    // shadow copy of the tables and per-category key counts
    logic [KEY_W-1:0]   slot_store [CATEGORIES][SLOTS];
    logic [COUNT_W-1:0] key_total [CATEGORIES];
    set_answer_t        answer_q [$];

    // murmur3 64-bit finaliser
    function automatic logic [63:0] fmix64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C1;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C2;
        x = x ^ (x >> MIX_SHIFT);
        return x;
    endfunction

    // one line per mismatch
    task automatic report_error(input string msg);
        $display("lphs_monitor: %0t ns: %s", $time, msg);
        failures++;
    endtask

    // apply one request to the shadow tables and queue the answer it gives
    task automatic probe_table(input logic [CMD_W-1:0] op,
                               input logic [CAT_FIELD_W-1:0] cat_in,
                               input logic [KEY_W-1:0] id);
        set_answer_t ans;
        int          c;
        int          pos;
        int          probes;
        bit          done;
        logic [KEY_W-1:0] held;
        c = int'(cat_in) % CATEGORIES;
        ans.slot = '0;
        if (id == '0)
        begin
            ans.st = ST_INVALID;
        end
        else
        begin
            pos = int'(fmix64({1'b0, id}) % SLOTS);
            ans.st = (op == CMD_LOOKUP) ? ST_MISSING : ST_FULL;
            done = 1'b0;
            probes = 0;
            // linear probe, wrapping past the last slot
            while (!done && probes < SLOTS)
            begin
                held = slot_store[c][pos];
                if (held == id)
                begin
                    ans.st = (op == CMD_LOOKUP) ? ST_FOUND : ST_PRESENT;
                    ans.slot = pos[SLOT_FIELD_W-1:0];
                    done = 1'b1;
                end
                else if (held == '0)
                begin
                    if (op == CMD_INSERT)
                    begin
                        slot_store[c][pos] = id;
                        key_total[c] = key_total[c] + 1'b1;
                        ans.st = ST_INSERTED;
                        ans.slot = pos[SLOT_FIELD_W-1:0];
                    end
                    done = 1'b1;
                end
                else
                begin
                    pos = (pos + 1) % SLOTS;
                    probes++;
                end
            end
        end
        ans.count = key_total[c];
        answer_q.push_back(ans);
    endtask

    // compare one accepted result with the oldest pending answer
    task automatic check_answer();
        set_answer_t want;
        if (answer_q.size() == 0)
        begin
            report_error($sformatf("unexpected result: status %0d slot %0d count %0d",
                                   status, slot_index, record_count));
        end
        else
        begin
            want = answer_q.pop_front();
            if (status !== want.st)
                report_error($sformatf("status %0d, expected %0d", status, want.st));
            if (slot_index !== want.slot)
                report_error($sformatf("slot_index %0d, expected %0d",
                                       slot_index, want.slot));
            if (record_count !== want.count)
                report_error($sformatf("record_count %0d, expected %0d",
                                       record_count, want.count));
        end
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_store[c, s])
                slot_store[c][s] = '0;
            foreach (key_total[c])
                key_total[c] = '0;
            answer_q.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_answer();
            if (req_valid && !req_stall)
                probe_table(command, category, title_id);
            outstanding <= answer_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// testbench: stimulus and verdict for linear_probe_hash_set. directed cases,
// a full-table fill of one category, then random traffic; depends on
// lphs_pkg, the block's rtl and lphs_monitor.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    typedef struct packed {
        logic [CAT_FIELD_W-1:0] cat;
        logic [KEY_W-1:0]       id;
    } stored_id_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [CMD_W-1:0]         command;
    logic [CAT_FIELD_W-1:0]   category;
    logic [KEY_W-1:0]         title_id;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic [COUNT_W-1:0]       record_count;
    int                       outstanding;
    int                       failures;

    int                       burst_left;
    stored_id_t               stored_ids [$];

    linear_probe_hash_set dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .category     (category),
        .title_id     (title_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot_index   (slot_index),
        .record_count (record_count)
    );

    lphs_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .category     (category),
        .title_id     (title_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot_index   (slot_index),
        .record_count (record_count),
        .outstanding  (outstanding),
        .failures     (failures)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure: free, random, mostly stalled, long holds
    initial
    begin : stall_pattern
        int pattern;
        int span;
        rsp_stall = 1'b0;
        forever
        begin
            pattern = $urandom_range(0, 3);
            span = $urandom_range(5, 80);
            repeat (span)
            begin
                @(posedge clk);
                case (pattern)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= 1'($urandom_range(0, 1));
                    2: rsp_stall <= ($urandom_range(0, 9) != 0);
                    default: rsp_stall <= ($urandom_range(0, 29) == 0) ? ~rsp_stall : rsp_stall;
                endcase
            end
        end
    end

    // watchdog: the clearing pass, a full-table fill and a few dozen whole-table
    // probes all finish well before this timeout
    initial
    begin
        #50_000_000;
        $display("** linear_probe_hash_set: FAILED **");
        $finish;
    end

    // sender bursts: short and long bursts with short and long gaps between
    task automatic pace_requests();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic issue_request(input logic [CMD_W-1:0] op,
                                 input logic [CAT_FIELD_W-1:0] cat,
                                 input logic [KEY_W-1:0] id);
        pace_requests();
        req_valid <= 1'b1;
        command   <= op;
        category  <= cat;
        title_id  <= id;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // hold off until every pending result has been taken
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_id();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            r = 64'($urandom_range(1, 255));
        return r[KEY_W-1:0];
    endfunction

    // a few categories take most traffic so chains build up; the full one is rare
    function automatic logic [CAT_FIELD_W-1:0] random_category();
        int r;
        r = $urandom_range(0, 99);
        if (r < 1)
            return CAT_FIELD_W'(CATEGORIES - 1);
        else if (r < 70)
            return CAT_FIELD_W'($urandom_range(0, 3));
        else
            return CAT_FIELD_W'($urandom_range(0, CATEGORIES - 2));
    endfunction

    initial
    begin : stimulus
        logic [KEY_W-1:0]       base;
        logic [KEY_W-1:0]       id;
        logic [CAT_FIELD_W-1:0] cat;
        logic [CAT_FIELD_W-1:0] full_cat;
        stored_id_t             pick;
        int                     r;
        int                     i;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        command    = CMD_INSERT;
        category   = '0;
        title_id   = '0;
        burst_left = 0;
        full_cat   = CAT_FIELD_W'(CATEGORIES - 1);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero id, empty lookup, extremes, duplicates, misses
        issue_request(CMD_INSERT, '0, '0);
        issue_request(CMD_LOOKUP, full_cat, '0);
        issue_request(CMD_LOOKUP, '0, KEY_W'(1));
        issue_request(CMD_INSERT, '0, KEY_W'(1));
        issue_request(CMD_INSERT, '0, '1);
        issue_request(CMD_INSERT, '0, KEY_W'(1));
        issue_request(CMD_LOOKUP, '0, '1);
        issue_request(CMD_LOOKUP, '0, KEY_W'(1));
        issue_request(CMD_LOOKUP, CAT_FIELD_W'(1), '1);
        issue_request(CMD_INSERT, CAT_FIELD_W'(17), KEY_W'({32{2'b01}}));
        issue_request(CMD_INSERT, CAT_FIELD_W'(10), KEY_W'({32{2'b10}}));
        issue_request(CMD_LOOKUP, CAT_FIELD_W'(17), KEY_W'({32{2'b01}}));
        issue_request(CMD_LOOKUP, '0, {1'b1, {(KEY_W-1){1'b0}}});
        issue_request(CMD_INSERT, '0, '0);
        stored_ids.push_back({CAT_FIELD_W'(0), KEY_W'(1)});
        stored_ids.push_back({CAT_FIELD_W'(0), {KEY_W{1'b1}}});

        // fill the last category past capacity; the final inserts find it full
        base = (random_id() >> 1) + 1'b1;
        for (i = 0; i < SLOTS + 4; i++)
            issue_request(CMD_INSERT, full_cat, base + KEY_W'(i));

        // full table: miss after every slot, full insert, hit, duplicate, zero id
        issue_request(CMD_LOOKUP, full_cat, base + KEY_W'(SLOTS + 100));
        issue_request(CMD_INSERT, full_cat, base + KEY_W'(SLOTS + 1));
        issue_request(CMD_LOOKUP, full_cat, base + KEY_W'(7));
        issue_request(CMD_INSERT, full_cat, base + KEY_W'(9));
        issue_request(CMD_LOOKUP, full_cat, base + KEY_W'(SLOTS - 1));
        issue_request(CMD_INSERT, full_cat, '0);
        wait_for_results();

        // random traffic: mostly inserts of fresh ids and lookups of known ones
        for (i = 0; i < 2000; i++)
        begin
            if (i == 1000)
                wait_for_results();
            r = $urandom_range(0, 99);
            cat = random_category();
            if (r < 5)
            begin
                issue_request($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, cat, '0);
            end
            else if (r < 40 || stored_ids.size() == 0)
            begin
                id = random_id();
                issue_request(CMD_INSERT, cat, id);
                stored_ids.push_back({cat, id});
            end
            else if (r < 55)
            begin
                pick = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
                issue_request(CMD_INSERT, pick.cat, pick.id);
            end
            else if (r < 85)
            begin
                pick = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
                issue_request(CMD_LOOKUP, pick.cat, pick.id);
            end
            else
            begin
                issue_request(CMD_LOOKUP, cat, random_id());
            end
        end

        // drain, then allow for a stray late result
        wait_for_results();
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("** linear_probe_hash_set: PASSED **");
        else
            $display("** linear_probe_hash_set: FAILED **");
        $finish;
    end

endmodule
